>>> rtl/long_press_gesture_detector_defines.svh
// Assertion macros shared by the long press gesture detector RTL.
`ifndef LONG_PRESS_GESTURE_DETECTOR_DEFINES_SVH
`define LONG_PRESS_GESTURE_DETECTOR_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, switched off while reset is asserted.
`define LPGD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("long press detector: implication check failed");
// Next-cycle implication, switched off while reset is asserted.
`define LPGD_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("long press detector: next-cycle check failed");
`else
`define LPGD_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define LPGD_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

>>> rtl/lpgd_pkg.sv
// Types, codes and reset values for the long press gesture detector.
package lpgd_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int TIMER_BITS_DEF = 16;
	localparam int RADIUS_W       = 17;
	localparam int CFG_IDX_W      = 3;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_RADIUS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_ENABLE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_X_MIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_X_MAX  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_Y_MIN  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_Y_MAX  = 3'd6;

	// Reset values; the region edges are truncated to the coordinate width.
	localparam logic [63:0] HOLD_TICKS_RST  = 64'd500;
	localparam logic [63:0] MOVE_RADIUS_RST = 64'd20;
	localparam logic [63:0] REGION_MIN_RST  = 64'h8000;
	localparam logic [63:0] REGION_MAX_RST  = 64'h7FFF;

	localparam logic OP_TOUCH = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam logic [2:0] ACT_DOWN     = 3'd0;
	localparam logic [2:0] ACT_MOVE     = 3'd1;
	localparam logic [2:0] ACT_UP       = 3'd2;
	localparam logic [2:0] ACT_PTR_DOWN = 3'd3;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_MAYBE    = 2'd1,
		PH_STARTED  = 2'd2,
		PH_FINISHED = 2'd3
	} phase_t;

	typedef struct packed {
		logic   advance;
		logic   timer_running;
		phase_t phase;
	} core_stat_t;

endpackage

>>> rtl/long_press_gesture_detector.sv
// Long press gesture detector: top level with configuration and core.
//
// Each transfer on the input channel is either a touch event or one timer
// tick, and yields exactly one result transfer carrying the trigger flag,
// the gesture phase after the item and the stored press point. The block
// takes one item per clock cycle unless the output stalls. An item is held
// in the input register and its result in the result register; the gesture
// update is done by the compare and add logic between the two registers.
// Input ready is high while the input register is empty or the result
// register is empty or being emptied in the same cycle, so a stalled output
// holds at most one further item. Configuration writes take effect on the
// next cycle; they are to be made while no item is in flight, which the block
// itself does not enforce. There is no clearing pass after reset.
`include "long_press_gesture_detector_defines.svh"
module long_press_gesture_detector #(
	parameter int COORD_BITS = lpgd_pkg::COORD_BITS_DEF,
	parameter int TIMER_BITS = lpgd_pkg::TIMER_BITS_DEF,
	localparam int HoldW = (TIMER_BITS > 9) ? TIMER_BITS : 9,
	localparam int CfgW  = (COORD_BITS > TIMER_BITS)
		? ((COORD_BITS > lpgd_pkg::RADIUS_W) ? COORD_BITS : lpgd_pkg::RADIUS_W)
		: ((TIMER_BITS > lpgd_pkg::RADIUS_W) ? TIMER_BITS : lpgd_pkg::RADIUS_W)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [lpgd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [CfgW-1:0]                   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              op,
	input  logic [2:0]                        action,
	input  logic [3:0]                        point_count,
	input  logic signed [COORD_BITS-1:0]      touch_x,
	input  logic signed [COORD_BITS-1:0]      touch_y,
	input  logic                              ignore,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              trigger,
	output logic [1:0]                        gest_phase,
	output logic signed [COORD_BITS-1:0]      press_x,
	output logic signed [COORD_BITS-1:0]      press_y
);

	logic [HoldW-1:0]                 hold_ticks_q;
	logic [lpgd_pkg::RADIUS_W-1:0]    move_radius_q;
	logic                             region_enable_q;
	logic signed [COORD_BITS-1:0]     region_x_min_q;
	logic signed [COORD_BITS-1:0]     region_x_max_q;
	logic signed [COORD_BITS-1:0]     region_y_min_q;
	logic signed [COORD_BITS-1:0]     region_y_max_q;
	lpgd_pkg::core_stat_t             stat;

	lpgd_cfg #(
		.COORD_BITS(COORD_BITS),
		.TIMER_BITS(TIMER_BITS)
	) u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wen         (cfg_wen),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.hold_ticks_q    (hold_ticks_q),
		.move_radius_q   (move_radius_q),
		.region_enable_q (region_enable_q),
		.region_x_min_q  (region_x_min_q),
		.region_x_max_q  (region_x_max_q),
		.region_y_min_q  (region_y_min_q),
		.region_y_max_q  (region_y_max_q)
	);

	lpgd_core #(
		.COORD_BITS(COORD_BITS),
		.TIMER_BITS(TIMER_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.action        (action),
		.point_count   (point_count),
		.touch_x       (touch_x),
		.touch_y       (touch_y),
		.ignore        (ignore),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.trigger       (trigger),
		.gest_phase    (gest_phase),
		.press_x       (press_x),
		.press_y       (press_y),
		.hold_ticks    (hold_ticks_q),
		.move_radius   (move_radius_q),
		.region_enable (region_enable_q),
		.region_x_min  (region_x_min_q),
		.region_x_max  (region_x_max_q),
		.region_y_min  (region_y_min_q),
		.region_y_max  (region_y_max_q),
		.stat          (stat)
	);

	// A trigger is only ever reported on entering started or finished.
	`LPGD_ASSERT_IMP(a_trig_phase, clk, arst_n, out_valid && trigger, (gest_phase == lpgd_pkg::PH_STARTED) || (gest_phase == lpgd_pkg::PH_FINISHED))
	// An idle result always carries a cleared press point.
	`LPGD_ASSERT_IMP(a_idle_clear, clk, arst_n, out_valid && (gest_phase == lpgd_pkg::PH_IDLE), (press_x == '0) && (press_y == '0))
	// The hold timer runs only while the gesture may still start.
	`LPGD_ASSERT_IMP(a_timer_maybe, clk, arst_n, stat.timer_running, stat.phase == lpgd_pkg::PH_MAYBE)
	// Every item that leaves the input register lands in the result register.
	`LPGD_ASSERT_NXT(a_adv_result, clk, arst_n, stat.advance, out_valid)

endmodule

>>> rtl/lpgd_cfg.sv
// Configuration register file of the long press gesture detector.
module lpgd_cfg #(
	parameter int COORD_BITS = lpgd_pkg::COORD_BITS_DEF,
	parameter int TIMER_BITS = lpgd_pkg::TIMER_BITS_DEF,
	localparam int HoldW = (TIMER_BITS > 9) ? TIMER_BITS : 9,
	localparam int CfgW  = (COORD_BITS > TIMER_BITS)
		? ((COORD_BITS > lpgd_pkg::RADIUS_W) ? COORD_BITS : lpgd_pkg::RADIUS_W)
		: ((TIMER_BITS > lpgd_pkg::RADIUS_W) ? TIMER_BITS : lpgd_pkg::RADIUS_W)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [lpgd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [CfgW-1:0]                     cfg_data,
	output logic [HoldW-1:0]                    hold_ticks_q,
	output logic [lpgd_pkg::RADIUS_W-1:0]       move_radius_q,
	output logic                                region_enable_q,
	output logic signed [COORD_BITS-1:0]        region_x_min_q,
	output logic signed [COORD_BITS-1:0]        region_x_max_q,
	output logic signed [COORD_BITS-1:0]        region_y_min_q,
	output logic signed [COORD_BITS-1:0]        region_y_max_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q    <= HoldW'(lpgd_pkg::HOLD_TICKS_RST);
			move_radius_q   <= lpgd_pkg::RADIUS_W'(lpgd_pkg::MOVE_RADIUS_RST);
			region_enable_q <= 1'b0;
			region_x_min_q  <= COORD_BITS'(lpgd_pkg::REGION_MIN_RST);
			region_x_max_q  <= COORD_BITS'(lpgd_pkg::REGION_MAX_RST);
			region_y_min_q  <= COORD_BITS'(lpgd_pkg::REGION_MIN_RST);
			region_y_max_q  <= COORD_BITS'(lpgd_pkg::REGION_MAX_RST);
		end else if (cfg_wen) begin
			unique case (cfg_index)
				lpgd_pkg::REG_HOLD_TICKS: begin
					hold_ticks_q <= HoldW'(cfg_data[TIMER_BITS-1:0]);
				end
				lpgd_pkg::REG_MOVE_RADIUS: begin
					move_radius_q <= cfg_data[lpgd_pkg::RADIUS_W-1:0];
				end
				lpgd_pkg::REG_REGION_ENABLE: begin
					region_enable_q <= cfg_data[0];
				end
				lpgd_pkg::REG_REGION_X_MIN: begin
					region_x_min_q <= cfg_data[COORD_BITS-1:0];
				end
				lpgd_pkg::REG_REGION_X_MAX: begin
					region_x_max_q <= cfg_data[COORD_BITS-1:0];
				end
				lpgd_pkg::REG_REGION_Y_MIN: begin
					region_y_min_q <= cfg_data[COORD_BITS-1:0];
				end
				lpgd_pkg::REG_REGION_Y_MAX: begin
					region_y_max_q <= cfg_data[COORD_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> rtl/lpgd_core.sv
// Input register, gesture state, next-state logic and result register.
module lpgd_core #(
	parameter int COORD_BITS = lpgd_pkg::COORD_BITS_DEF,
	parameter int TIMER_BITS = lpgd_pkg::TIMER_BITS_DEF,
	localparam int HoldW = (TIMER_BITS > 9) ? TIMER_BITS : 9,
	localparam int DistW = (COORD_BITS + 1 > lpgd_pkg::RADIUS_W)
		? COORD_BITS + 1 : lpgd_pkg::RADIUS_W
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             op,
	input  logic [2:0]                       action,
	input  logic [3:0]                       point_count,
	input  logic signed [COORD_BITS-1:0]     touch_x,
	input  logic signed [COORD_BITS-1:0]     touch_y,
	input  logic                             ignore,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             trigger,
	output logic [1:0]                       gest_phase,
	output logic signed [COORD_BITS-1:0]     press_x,
	output logic signed [COORD_BITS-1:0]     press_y,
	input  logic [HoldW-1:0]                 hold_ticks,
	input  logic [lpgd_pkg::RADIUS_W-1:0]    move_radius,
	input  logic                             region_enable,
	input  logic signed [COORD_BITS-1:0]     region_x_min,
	input  logic signed [COORD_BITS-1:0]     region_x_max,
	input  logic signed [COORD_BITS-1:0]     region_y_min,
	input  logic signed [COORD_BITS-1:0]     region_y_max,
	output lpgd_pkg::core_stat_t             stat
);

	// Input stage.
	logic                          valid_s1;
	logic                          op_s1;
	logic [2:0]                    action_s1;
	logic [3:0]                    count_s1;
	logic signed [COORD_BITS-1:0]  tx_s1;
	logic signed [COORD_BITS-1:0]  ty_s1;
	logic                          ign_s1;

	// Gesture state.
	lpgd_pkg::phase_t              phase_q;
	lpgd_pkg::phase_t              phase_d;
	logic signed [COORD_BITS-1:0]  anchor_x_q;
	logic signed [COORD_BITS-1:0]  anchor_y_q;
	logic signed [COORD_BITS-1:0]  anchor_x_d;
	logic signed [COORD_BITS-1:0]  anchor_y_d;
	logic [TIMER_BITS-1:0]         hold_count_q;
	logic [TIMER_BITS-1:0]         hold_count_d;
	logic                          timer_running_q;
	logic                          timer_running_d;
	logic                          trig_d;

	// Result stage.
	logic                          valid_s2;
	logic                          trig_s2;
	lpgd_pkg::phase_t              phase_s2;
	logic signed [COORD_BITS-1:0]  press_x_s2;
	logic signed [COORD_BITS-1:0]  press_y_s2;

	logic                          out_free;
	logic                          advance;

	logic                          is_tick;
	logic                          is_touch;
	logic [TIMER_BITS-1:0]         count_inc;
	logic                          fire;
	logic                          in_rect;
	logic                          out_of_bounds;
	logic signed [COORD_BITS:0]    dx;
	logic signed [COORD_BITS:0]    dy;
	logic [COORD_BITS-1:0]         abs_dx;
	logic [COORD_BITS-1:0]         abs_dy;
	logic [DistW-1:0]              man_dist;
	logic                          too_far;
	logic                          act_abort;
	logic                          do_abort;
	logic                          clear_any;
	logic                          do_down;
	logic                          tick_start;

	assign out_free = !valid_s2 || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1     <= op;
			action_s1 <= action;
			count_s1  <= point_count;
			tx_s1     <= touch_x;
			ty_s1     <= touch_y;
			ign_s1    <= ignore;
		end
	end

	// Decoding of the item held in the input stage.
	assign is_tick  = (op_s1 == lpgd_pkg::OP_TICK);
	assign is_touch = (op_s1 == lpgd_pkg::OP_TOUCH);

	// The hold counter saturates at all ones.
	assign count_inc = (&hold_count_q) ? hold_count_q : hold_count_q + 1'b1;
	assign fire      = HoldW'(count_inc) >= hold_ticks;

	assign in_rect = !region_enable ||
		(tx_s1 >= region_x_min && tx_s1 <= region_x_max &&
		 ty_s1 >= region_y_min && ty_s1 <= region_y_max);
	assign out_of_bounds = (count_s1 != 4'd1) || !in_rect;

	assign dx     = {anchor_x_q[COORD_BITS-1], anchor_x_q} - {tx_s1[COORD_BITS-1], tx_s1};
	assign dy     = {anchor_y_q[COORD_BITS-1], anchor_y_q} - {ty_s1[COORD_BITS-1], ty_s1};
	assign abs_dx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
	assign abs_dy = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
	assign man_dist = DistW'(abs_dx) + DistW'(abs_dy);
	assign too_far  = man_dist > DistW'(move_radius);

	// A far move outside a live gesture aborts nothing, as idle and finished
	// ignore an abort that does not clear.
	assign act_abort = (action_s1 == lpgd_pkg::ACT_UP) ||
		(action_s1 == lpgd_pkg::ACT_PTR_DOWN) ||
		((action_s1 == lpgd_pkg::ACT_MOVE) && too_far);
	assign do_abort   = is_touch && (ign_s1 || out_of_bounds || act_abort);
	assign clear_any  = is_touch && !ign_s1 && out_of_bounds;
	assign do_down    = is_touch && !ign_s1 && !out_of_bounds &&
		(action_s1 == lpgd_pkg::ACT_DOWN);
	assign tick_start = is_tick && timer_running_q && fire &&
		(phase_q == lpgd_pkg::PH_MAYBE);

	// Next gesture phase.
	always_comb begin
		phase_d = phase_q;
		if (tick_start) begin
			phase_d = lpgd_pkg::PH_STARTED;
		end else if (do_down) begin
			phase_d = lpgd_pkg::PH_MAYBE;
		end else if (do_abort) begin
			unique case (phase_q)
				lpgd_pkg::PH_STARTED: begin
					phase_d = lpgd_pkg::PH_FINISHED;
				end
				lpgd_pkg::PH_MAYBE: begin
					phase_d = lpgd_pkg::PH_IDLE;
				end
				default: begin
					if (clear_any) begin
						phase_d = lpgd_pkg::PH_IDLE;
					end
				end
			endcase
		end
	end

	// Trigger, press point and hold timer.
	always_comb begin
		trig_d          = tick_start ||
			(do_abort && phase_q == lpgd_pkg::PH_STARTED);
		anchor_x_d      = anchor_x_q;
		anchor_y_d      = anchor_y_q;
		hold_count_d    = hold_count_q;
		timer_running_d = timer_running_q;
		if (is_tick) begin
			if (timer_running_q) begin
				hold_count_d    = count_inc;
				timer_running_d = !fire;
			end
		end else if (do_down) begin
			anchor_x_d      = tx_s1;
			anchor_y_d      = ty_s1;
			hold_count_d    = '0;
			timer_running_d = 1'b1;
		end else if (do_abort && phase_q != lpgd_pkg::PH_STARTED) begin
			if (phase_q == lpgd_pkg::PH_MAYBE) begin
				timer_running_d = 1'b0;
			end
			if (phase_q == lpgd_pkg::PH_MAYBE || clear_any) begin
				anchor_x_d = '0;
				anchor_y_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= lpgd_pkg::PH_IDLE;
			anchor_x_q      <= '0;
			anchor_y_q      <= '0;
			hold_count_q    <= '0;
			timer_running_q <= 1'b0;
		end else if (advance) begin
			phase_q         <= phase_d;
			anchor_x_q      <= anchor_x_d;
			anchor_y_q      <= anchor_y_d;
			hold_count_q    <= hold_count_d;
			timer_running_q <= timer_running_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			trig_s2    <= trig_d;
			phase_s2   <= phase_d;
			press_x_s2 <= anchor_x_d;
			press_y_s2 <= anchor_y_d;
		end
	end

	assign out_valid  = valid_s2;
	assign trigger    = trig_s2;
	assign gest_phase = phase_s2;
	assign press_x    = press_x_s2;
	assign press_y    = press_y_s2;

	assign stat.advance       = advance;
	assign stat.timer_running = timer_running_q;
	assign stat.phase         = phase_q;

endmodule

>>> tb/long_press_gesture_detector_test.sv
// Self-checking testbench for the long press gesture detector.
module long_press_gesture_detector_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lpgd_pkg::*;

	localparam int CW             = COORD_BITS_DEF;
	localparam int CFG_W          = RADIUS_W;
	localparam int COORD_MAX      = 32767;
	localparam int COORD_MIN      = -32768;
	localparam int LONG_STALL     = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_PRINTED    = 20;

	// Action codes that the package leaves unnamed.
	localparam logic [2:0] ACT_PTR_UP = 3'd4;
	localparam logic [2:0] ACT_LAST   = 3'd7;

	typedef struct {
		logic                 op;
		logic [2:0]           action;
		logic [3:0]           count;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic                 ign;
	} touch_item_t;

	typedef struct {
		logic                 trig;
		phase_t               state;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
	} gesture_result_t;

	typedef struct {
		logic [15:0]          hold;
		logic [CFG_W-1:0]     radius;
		logic                 en;
		logic signed [CW-1:0] xmin;
		logic signed [CW-1:0] xmax;
		logic signed [CW-1:0] ymin;
		logic signed [CW-1:0] ymax;
	} det_cfg_t;

	class gesture_scoreboard;
		det_cfg_t             setting;
		phase_t               phase;
		logic signed [CW-1:0] anchor_x;
		logic signed [CW-1:0] anchor_y;
		logic [15:0]          hold_count;
		bit                   timer_on;
		gesture_result_t      pending_results[$];
		int errors, n_items, n_results, n_trig, n_started, n_finished;

		function new();
			setting.hold   = HOLD_TICKS_RST[15:0];
			setting.radius = MOVE_RADIUS_RST[CFG_W-1:0];
			setting.en     = 1'b0;
			setting.xmin   = REGION_MIN_RST[CW-1:0];
			setting.xmax   = REGION_MAX_RST[CW-1:0];
			setting.ymin   = REGION_MIN_RST[CW-1:0];
			setting.ymax   = REGION_MAX_RST[CW-1:0];
			phase      = PH_IDLE;
			anchor_x   = '0;
			anchor_y   = '0;
			hold_count = '0;
			timer_on   = 1'b0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		// A started gesture finishes with a trigger; a maybe gesture is dropped.
		function bit leave_gesture(bit clear_any);
			if (phase == PH_STARTED) begin
				phase = PH_FINISHED;
				return 1'b1;
			end
			if (phase == PH_MAYBE)
				timer_on = 1'b0;
			if (phase == PH_MAYBE || clear_any) begin
				phase    = PH_IDLE;
				anchor_x = '0;
				anchor_y = '0;
			end
			return 1'b0;
		endfunction

		function bit in_region(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
			if (!setting.en)
				return 1'b1;
			return x >= setting.xmin && x <= setting.xmax &&
				y >= setting.ymin && y <= setting.ymax;
		endfunction

		function void take_item(touch_item_t it);
			bit trig;
			int dx, dy;
			trig = 1'b0;
			if (it.op == OP_TICK) begin
				if (timer_on) begin
					if (hold_count != 16'hFFFF)
						hold_count++;
					if (hold_count >= setting.hold) begin
						timer_on = 1'b0;
						if (phase == PH_MAYBE) begin
							phase = PH_STARTED;
							trig  = 1'b1;
						end
					end
				end
			end else if (it.ign) begin
				trig = leave_gesture(1'b0);
			end else if (it.count != 4'd1 || !in_region(it.x, it.y)) begin
				trig = leave_gesture(1'b1);
			end else begin
				case (it.action)
					ACT_DOWN: begin
						anchor_x   = it.x;
						anchor_y   = it.y;
						phase      = PH_MAYBE;
						hold_count = '0;
						timer_on   = 1'b1;
					end
					ACT_MOVE: begin
						if (phase == PH_MAYBE || phase == PH_STARTED) begin
							dx = int'(anchor_x) - int'(it.x);
							dy = int'(anchor_y) - int'(it.y);
							if (dx < 0) dx = -dx;
							if (dy < 0) dy = -dy;
							if (dx + dy > int'(setting.radius))
								trig = leave_gesture(1'b0);
						end
					end
					ACT_UP, ACT_PTR_DOWN: trig = leave_gesture(1'b0);
					default: ;
				endcase
			end
			n_items++;
			if (trig) begin
				n_trig++;
				if (phase == PH_STARTED) n_started++;
				if (phase == PH_FINISHED) n_finished++;
			end
			pending_results.push_back('{trig, phase, anchor_x, anchor_y});
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("%0t ns result %0d: %s", $time, n_results, msg);
		endtask

		task check_result(gesture_result_t got);
			gesture_result_t want;
			n_results++;
			if (pending_results.size() == 0) begin
				report("result transfer with nothing expected");
				return;
			end
			want = pending_results.pop_front();
			if (got.trig !== want.trig)
				report($sformatf("trigger %b, expected %b", got.trig, want.trig));
			if (got.state !== want.state)
				report($sformatf("gest_phase %0d, expected %0d", got.state, want.state));
			if (got.x !== want.x)
				report($sformatf("press_x %0d, expected %0d", got.x, want.x));
			if (got.y !== want.y)
				report($sformatf("press_y %0d, expected %0d", got.y, want.y));
		endtask

		task check_drained();
			if (pending_results.size() != 0)
				report($sformatf("%0d results never arrived", pending_results.size()));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 op;
	logic [2:0]           action;
	logic [3:0]           point_count;
	logic signed [CW-1:0] touch_x;
	logic signed [CW-1:0] touch_y;
	logic                 ignore;
	logic                 out_valid;
	logic                 out_ready;
	logic                 trigger;
	logic [1:0]           gest_phase;
	logic signed [CW-1:0] press_x;
	logic signed [CW-1:0] press_y;

	gesture_scoreboard sb;
	det_cfg_t          cur_cfg;
	int                burst_left = 0;
	int                sent_items = 0;
	int                n_settings = 0;
	int                hold_offs  = 0;
	bit                hold_off_pending = 1'b0;

	long_press_gesture_detector dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.action(action),
		.point_count(point_count),
		.touch_x(touch_x),
		.touch_y(touch_y),
		.ignore(ignore),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.trigger(trigger),
		.gest_phase(gest_phase),
		.press_x(press_x),
		.press_y(press_y)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic signed [CW-1:0] clamp_coord(int v);
		if (v > COORD_MAX) v = COORD_MAX;
		if (v < COORD_MIN) v = COORD_MIN;
		return CW'(v);
	endfunction

	function automatic int rand_coord();
		return int'($urandom_range(0, 65535)) + COORD_MIN;
	endfunction

	function automatic int flip(int v);
		return ($urandom_range(0, 1) != 0) ? -v : v;
	endfunction

	// Points on the edges are favoured, since the rectangle is inclusive.
	function automatic int pick_between(logic signed [CW-1:0] lo, logic signed [CW-1:0] hi);
		int l, h;
		l = lo;
		h = hi;
		case ($urandom_range(0, 9))
			0: return l;
			1: return h;
			default: return l + int'($urandom_range(0, h - l));
		endcase
	endfunction

	function automatic touch_item_t random_item();
		touch_item_t it;
		it.op     = 1'($urandom);
		it.action = 3'($urandom);
		it.count  = 4'($urandom);
		it.x      = CW'($urandom);
		it.y      = CW'($urandom);
		it.ign    = 1'($urandom);
		return it;
	endfunction

	function automatic det_cfg_t random_setting();
		det_cfg_t             c;
		int                   cx, cy, hx, hy;
		logic signed [CW-1:0] t;
		case ($urandom_range(0, 9))
			0: c.hold = 16'd1;
			1: c.hold = 16'hFFFF;
			default: c.hold = 16'($urandom_range(1, 12));
		endcase
		case ($urandom_range(0, 7))
			0: c.radius = '0;
			1: c.radius = '1;
			2: c.radius = CFG_W'($urandom);
			default: c.radius = CFG_W'($urandom_range(1, 150));
		endcase
		c.en = ($urandom_range(0, 3) != 0);
		cx = rand_coord();
		cy = rand_coord();
		hx = $urandom_range(0, 4000);
		hy = $urandom_range(0, 4000);
		c.xmin = clamp_coord(cx - hx);
		c.xmax = clamp_coord(cx + hx);
		c.ymin = clamp_coord(cy - hy);
		c.ymax = clamp_coord(cy + hy);
		// Now and then an inverted rectangle, which holds no point at all.
		if ($urandom_range(0, 9) == 0) begin
			t      = c.xmin;
			c.xmin = c.xmax;
			c.xmax = t;
		end
		return c;
	endfunction

	task automatic send_item(touch_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid    <= 1'b1;
		op          <= it.op;
		action      <= it.action;
		point_count <= it.count;
		touch_x     <= it.x;
		touch_y     <= it.y;
		ignore      <= it.ign;
		do @(posedge clk); while (!in_ready);
		sent_items++;
	endtask

	task automatic touch(logic [2:0] act, logic [3:0] cnt, int x, int y, logic ign = 1'b0);
		send_item('{OP_TOUCH, act, cnt, clamp_coord(x), clamp_coord(y), ign});
	endtask

	// A tick carries random rubbish in every other field.
	task automatic tick();
		touch_item_t it;
		it    = random_item();
		it.op = OP_TICK;
		send_item(it);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// Registers change only once every transfer in flight has come out.
	task automatic apply_config(det_cfg_t c);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(REG_HOLD_TICKS, CFG_W'(c.hold));
		write_reg(REG_MOVE_RADIUS, c.radius);
		write_reg(REG_REGION_ENABLE, CFG_W'(c.en));
		write_reg(REG_REGION_X_MIN, CFG_W'($unsigned(c.xmin)));
		write_reg(REG_REGION_X_MAX, CFG_W'($unsigned(c.xmax)));
		write_reg(REG_REGION_Y_MIN, CFG_W'($unsigned(c.ymin)));
		write_reg(REG_REGION_Y_MAX, CFG_W'($unsigned(c.ymax)));
		cfg_wen    <= 1'b0;
		sb.setting  = c;
		cur_cfg     = c;
		n_settings++;
	endtask

	// One press with random content: moves, ticks and noise, then a way out or none.
	task automatic gesture_run();
		int ax, ay, steps, lim, r, dx, dy, d;
		if (cur_cfg.en && cur_cfg.xmin <= cur_cfg.xmax && cur_cfg.ymin <= cur_cfg.ymax &&
				$urandom_range(0, 9) != 0) begin
			ax = pick_between(cur_cfg.xmin, cur_cfg.xmax);
			ay = pick_between(cur_cfg.ymin, cur_cfg.ymax);
		end else begin
			ax = rand_coord();
			ay = rand_coord();
		end
		touch(ACT_DOWN, 4'd1, ax, ay);
		steps = $urandom_range(1, ((cur_cfg.hold > 20) ? 20 : int'(cur_cfg.hold)) + 6);
		lim = (cur_cfg.radius > 300) ? 300 : int'(cur_cfg.radius);
		repeat (steps) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				tick();
			end else if (r < 75) begin
				dx = $urandom_range(0, lim);
				dy = $urandom_range(0, lim - dx);
				touch(ACT_MOVE, 4'd1, ax + flip(dx), ay + flip(dy));
			end else if (r < 82) begin
				d = int'(cur_cfg.radius) + 1 + int'($urandom_range(0, 40));
				if (d > 60000) begin
					touch(ACT_MOVE, 4'd1, (ax >= 0) ? COORD_MIN : COORD_MAX,
						(ay >= 0) ? COORD_MIN : COORD_MAX);
				end else begin
					dx = $urandom_range(0, d);
					touch(ACT_MOVE, 4'd1, ax + flip(dx), ay + flip(d - dx));
				end
			end else if (r < 88) begin
				touch(3'($urandom_range(ACT_PTR_UP, ACT_LAST)), 4'd1, ax, ay);
			end else begin
				send_item(random_item());
			end
		end
		case ($urandom_range(0, 6))
			0: touch(ACT_UP, 4'd1, ax, ay);
			1: touch(ACT_PTR_DOWN, 4'd1, ax, ay);
			2: touch(3'($urandom), 4'($urandom), ax, ay, 1'b1);
			3: touch(ACT_MOVE, ($urandom_range(0, 1) != 0) ? 4'd0 : 4'($urandom_range(2, 15)),
				ax, ay);
			4: touch(ACT_MOVE, 4'd1, rand_coord(), rand_coord());
			default: ;
		endcase
		repeat ($urandom_range(0, 2)) send_item(random_item());
	endtask

	task automatic run_phase(int n);
		int first;
		first = sent_items;
		while (sent_items - first < n) gesture_run();
	endtask

	// Receiver: stretches of steady, random, periodic or heavy back-pressure.
	initial begin
		int mode;
		int stretch;
		int cyc;
		mode    = 0;
		stretch = 0;
		cyc     = 0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (stretch == 0) begin
				mode    = $urandom_range(0, 3);
				stretch = $urandom_range(20, 150);
			end
			@(posedge clk);
			stretch--;
			cyc++;
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
				hold_offs++;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 99) >= 35);
					2: out_ready <= (cyc % 3 != 0);
					default: out_ready <= ($urandom_range(0, 99) >= 70);
				endcase
			end
		end
	end

	// Both channels are sampled at the edge on which a transfer happens.
	always @(posedge clk) begin
		gesture_result_t seen;
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.take_item('{op, action, point_count, touch_x, touch_y, ignore});
			if (out_valid && out_ready) begin
				seen.trig  = trigger;
				seen.state = phase_t'(gest_phase);
				seen.x     = press_x;
				seen.y     = press_y;
				sb.check_result(seen);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		det_cfg_t c;
		sb = new();
		cur_cfg = sb.setting;
		arst_n      <= 1'b0;
		cfg_wen     <= 1'b0;
		cfg_index   <= REG_HOLD_TICKS;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		op          <= OP_TOUCH;
		action      <= ACT_DOWN;
		point_count <= '0;
		touch_x     <= '0;
		touch_y     <= '0;
		ignore      <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: long hold, radius of twenty, no region.
		tick();
		touch(ACT_DOWN, 4'd0, 0, 0);
		touch(ACT_DOWN, 4'd1, COORD_MIN, COORD_MAX);
		touch(ACT_MOVE, 4'd1, COORD_MIN + 20, COORD_MAX);
		touch(ACT_PTR_UP, 4'd1, 0, 0);
		touch(ACT_LAST, 4'd1, 0, 0);
		tick();
		touch(ACT_MOVE, 4'd1, COORD_MIN + 21, COORD_MAX);
		touch(ACT_MOVE, 4'd1, 0, 0);
		touch(ACT_UP, 4'd1, 0, 0, 1'b1);
		touch(ACT_DOWN, 4'd1, COORD_MAX, COORD_MIN);
		touch(ACT_DOWN, 4'd1, 0, 0);
		touch(ACT_PTR_DOWN, 4'd1, 0, 0);
		touch(ACT_DOWN, 4'd1, 5, 5);
		touch(ACT_DOWN, 4'd15, 5, 5);

		// Zero hold fires on the first tick; zero radius tolerates no move.
		c = '{16'd0, '0, 1'b1, -16'sd100, 16'sd100, -16'sd100, 16'sd100};
		apply_config(c);
		touch(ACT_DOWN, 4'd1, -100, 100);
		tick();
		tick();
		touch(ACT_MOVE, 4'd1, -100, 100);
		touch(ACT_MOVE, 4'd1, -99, 100);
		touch(ACT_UP, 4'd1, 0, 0, 1'b1);
		touch(ACT_DOWN, 4'd1, 101, 0);
		touch(ACT_DOWN, 4'd1, 0, 0);
		tick();
		touch(ACT_UP, 4'd1, 0, 0);

		c = '{16'hFFFF, '1, 1'b1, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767};
		apply_config(c);
		run_phase(60);
		c = '{16'd1, '0, 1'b1, 16'sd10, -16'sd10, -16'sd32768, 16'sd32767};
		apply_config(c);
		run_phase(40);
		for (int k = 0; k < 8; k++) begin
			apply_config(random_setting());
			if (k == 0)
				hold_off_pending = 1'b1;
			run_phase(110);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		sb.check_drained();
		$display("Ran %0d touch and tick items through %0d register settings, %0d results checked.",
			sb.n_items, n_settings, sb.n_results);
		$display("Saw %0d triggers: %0d long presses started, %0d finished; %0d long output stalls.",
			sb.n_trig, sb.n_started, sb.n_finished, hold_offs);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
